// File: src/binary_field_multiplier_top_macros.svh
// Assertion macros for the binary field multiplier.
// Taken in by binary_field_multiplier_top; depends on a clk and rst_n in scope.
`ifndef BINARY_FIELD_MULTIPLIER_TOP_MACROS_SVH
`define BINARY_FIELD_MULTIPLIER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bfm_pkg.sv
// Shared types and constants for the binary field multiplier.
// No dependencies; used by bfm_clmul64, bfm_fold and the top level.
package bfm_pkg;

  localparam int WORD_W = 64;
  localparam int NWORDS = 4;
  localparam int NPROD  = 2 * NWORDS;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [2*WORD_W-1:0] dword_t;
  typedef word_t [NWORDS-1:0]  elem_t;
  typedef word_t [NPROD-1:0]   prod_t;
  typedef logic [1:0]          func_t;

  localparam func_t FUNC_128  = 2'd0;
  localparam func_t FUNC_192  = 2'd1;
  localparam func_t FUNC_256  = 2'd2;
  localparam func_t FUNC_RSVD = 2'd3;

  typedef struct packed {
    logic  vld;
    func_t func;
  } ctl_t;

endpackage

// File: src/binary_field_multiplier_top.sv
// Binary field multiplier top level: GF(2^128), GF(2^192), GF(2^256).
// Depends on bfm_pkg, bfm_clmul64, bfm_fold and the assertion macro header.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | in_func, in_a_w0..3, in_b_w0..3
//  out     | out_valid / out_ready| out_c_w0..3
//
// Four register stages: operand capture, 16 carry-less 64x64 partial products,
// product word accumulation, field fold into the output register.
// One item per cycle is accepted when the output is taken.
// Each stage holds its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up during an output stall.
// rst_n synchronously clears the valid bits; payload registers are not reset.
`include "binary_field_multiplier_top_macros.svh"

module binary_field_multiplier_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfm_pkg::func_t        in_func,
  input  bfm_pkg::word_t        in_a_w0,
  input  bfm_pkg::word_t        in_a_w1,
  input  bfm_pkg::word_t        in_a_w2,
  input  bfm_pkg::word_t        in_a_w3,
  input  bfm_pkg::word_t        in_b_w0,
  input  bfm_pkg::word_t        in_b_w1,
  input  bfm_pkg::word_t        in_b_w2,
  input  bfm_pkg::word_t        in_b_w3,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfm_pkg::word_t        out_c_w0,
  output bfm_pkg::word_t        out_c_w1,
  output bfm_pkg::word_t        out_c_w2,
  output bfm_pkg::word_t        out_c_w3
);

  bfm_pkg::ctl_t  s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic           rdy1, rdy2, rdy3, rdy4;

  bfm_pkg::elem_t a_m, b_m;
  bfm_pkg::elem_t a_r, b_r;

  bfm_pkg::dword_t prod [bfm_pkg::NWORDS][bfm_pkg::NWORDS];
  bfm_pkg::dword_t prod_r [bfm_pkg::NWORDS][bfm_pkg::NWORDS];

  bfm_pkg::prod_t d_nxt, d_r;
  bfm_pkg::elem_t c_nxt, c_r;

  // ready chain: a stage may load when empty or when its successor moves
  assign rdy4     = !s4_ctl_r.vld || out_ready;
  assign rdy3     = !s3_ctl_r.vld || rdy4;
  assign rdy2     = !s2_ctl_r.vld || rdy3;
  assign rdy1     = !s1_ctl_r.vld || rdy2;
  assign in_ready = rdy1;

  // drop operand words above the selected field
  always_comb begin
    a_m = '0;
    b_m = '0;
    case (in_func)
      bfm_pkg::FUNC_128: begin
        a_m[0] = in_a_w0;  a_m[1] = in_a_w1;
        b_m[0] = in_b_w0;  b_m[1] = in_b_w1;
      end
      bfm_pkg::FUNC_192: begin
        a_m[0] = in_a_w0;  a_m[1] = in_a_w1;  a_m[2] = in_a_w2;
        b_m[0] = in_b_w0;  b_m[1] = in_b_w1;  b_m[2] = in_b_w2;
      end
      bfm_pkg::FUNC_256: begin
        a_m[0] = in_a_w0;  a_m[1] = in_a_w1;  a_m[2] = in_a_w2;  a_m[3] = in_a_w3;
        b_m[0] = in_b_w0;  b_m[1] = in_b_w1;  b_m[2] = in_b_w2;  b_m[3] = in_b_w3;
      end
      default: begin
        a_m = '0;
        b_m = '0;
      end
    endcase
  end

  genvar gi, gj;
  generate
    for (gi = 0; gi < bfm_pkg::NWORDS; gi++) begin : g_row
      for (gj = 0; gj < bfm_pkg::NWORDS; gj++) begin : g_col
        bfm_clmul64 u_clmul (
          .x (a_r[gi]),
          .y (b_r[gj]),
          .p (prod[gi][gj])
        );
      end
    end
  endgenerate

  // gather partial products into product words
  always_comb begin
    d_nxt = '0;
    for (int i = 0; i < bfm_pkg::NWORDS; i++) begin
      for (int j = 0; j < bfm_pkg::NWORDS; j++) begin
        d_nxt[i+j]   = d_nxt[i+j]   ^ prod_r[i][j][bfm_pkg::WORD_W-1:0];
        d_nxt[i+j+1] = d_nxt[i+j+1] ^ prod_r[i][j][2*bfm_pkg::WORD_W-1:bfm_pkg::WORD_W];
      end
    end
  end

  bfm_fold u_fold (
    .func (s3_ctl_r.func),
    .d_in (d_r),
    .c    (c_nxt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else begin
      if (rdy1) begin
        s1_ctl_r.vld  <= in_valid;
        s1_ctl_r.func <= in_func;
      end
      if (rdy2) s2_ctl_r <= s1_ctl_r;
      if (rdy3) s3_ctl_r <= s2_ctl_r;
      if (rdy4) s4_ctl_r <= s3_ctl_r;
    end
  end

  // payload, held while a stage is stalled
  always_ff @(posedge clk) begin
    if (rdy1) begin
      a_r <= a_m;
      b_r <= b_m;
    end
    if (rdy2) begin
      prod_r <= prod;
    end
    if (rdy3) begin
      d_r <= d_nxt;
    end
    if (rdy4) begin
      c_r <= c_nxt;
    end
  end

  assign out_valid = s4_ctl_r.vld;
  assign out_c_w0  = c_r[0];
  assign out_c_w1  = c_r[1];
  assign out_c_w2  = c_r[2];
  assign out_c_w3  = c_r[3];

  `BFM_ASSERT_IMP(a_full_when_blocked, !in_ready,
    s1_ctl_r.vld && s2_ctl_r.vld && s3_ctl_r.vld && s4_ctl_r.vld,
    "input blocked while a pipeline stage is empty")

  `BFM_ASSERT_IMP(a_gf128_upper_zero, out_valid && s4_ctl_r.func == bfm_pkg::FUNC_128,
    out_c_w2 == '0 && out_c_w3 == '0,
    "GF(2^128) result has nonzero upper words")

  `BFM_ASSERT_IMP(a_rsvd_zero, out_valid && s4_ctl_r.func == bfm_pkg::FUNC_RSVD,
    out_c_w0 == '0 && out_c_w1 == '0 && out_c_w2 == '0 && out_c_w3 == '0,
    "reserved field select gave a nonzero result")

  `BFM_ASSERT_NXT(a_stage_advance, s3_ctl_r.vld && rdy4,
    s4_ctl_r.vld,
    "item lost between fold and output stage")

endmodule

// File: src/bfm_clmul64.sv
// 64x64 carry-less multiplier, combinational.
// Depends on bfm_pkg for word types.
module bfm_clmul64 (
  input  bfm_pkg::word_t  x,
  input  bfm_pkg::word_t  y,
  output bfm_pkg::dword_t p
);

  always_comb begin
    bfm_pkg::dword_t acc;
    acc = '0;
    // each term is independent; synthesis builds an XOR tree
    for (int i = 0; i < bfm_pkg::WORD_W; i++) begin
      if (y[i]) begin
        acc = acc ^ ({{bfm_pkg::WORD_W{1'b0}}, x} << i);
      end
    end
    p = acc;
  end

endmodule

// File: src/bfm_fold.sv
// Field reduction: folds the high product words down, top word first.
// Depends on bfm_pkg for word, product and field select types.
module bfm_fold (
  input  bfm_pkg::func_t func,
  input  bfm_pkg::prod_t d_in,
  output bfm_pkg::elem_t c
);

  // x^7 + x^2 + x + 1
  function automatic bfm_pkg::word_t down_small(bfm_pkg::word_t w);
    return w ^ (w << 1) ^ (w << 2) ^ (w << 7);
  endfunction

  function automatic bfm_pkg::word_t up_small(bfm_pkg::word_t w);
    return (w >> 63) ^ (w >> 62) ^ (w >> 57);
  endfunction

  // x^10 + x^5 + x^2 + 1
  function automatic bfm_pkg::word_t down_256(bfm_pkg::word_t w);
    return w ^ (w << 2) ^ (w << 5) ^ (w << 10);
  endfunction

  function automatic bfm_pkg::word_t up_256(bfm_pkg::word_t w);
    return (w >> 62) ^ (w >> 59) ^ (w >> 54);
  endfunction

  always_comb begin
    bfm_pkg::prod_t d;
    d = d_in;
    c = '0;
    case (func)
      bfm_pkg::FUNC_128: begin
        for (int k = 3; k >= 2; k--) begin
          d[k-2] = d[k-2] ^ down_small(d[k]);
          d[k-1] = d[k-1] ^ up_small(d[k]);
        end
        c[0] = d[0];
        c[1] = d[1];
      end
      bfm_pkg::FUNC_192: begin
        for (int k = 5; k >= 3; k--) begin
          d[k-3] = d[k-3] ^ down_small(d[k]);
          d[k-2] = d[k-2] ^ up_small(d[k]);
        end
        c[0] = d[0];
        c[1] = d[1];
        c[2] = d[2];
      end
      bfm_pkg::FUNC_256: begin
        for (int k = 7; k >= 4; k--) begin
          d[k-4] = d[k-4] ^ down_256(d[k]);
          d[k-3] = d[k-3] ^ up_256(d[k]);
        end
        c[0] = d[0];
        c[1] = d[1];
        c[2] = d[2];
        c[3] = d[3];
      end
      default: begin
        c = '0;
      end
    endcase
  end

endmodule
